@@ sv/im2c_pkg.sv @@
// Shared constants, register codes and types of the im2col patch streamer.
package im2c_pkg;

    localparam int DATA_W       = 32;
    localparam int MAX_KERNEL   = 8;
    localparam int MAX_STRIDE   = 8;
    localparam int MAX_COLUMNS  = 256;
    localparam int MAX_ROWS     = 256;
    localparam int MAX_CHANNELS = 16;

    localparam int KW        = 4;
    localparam int SW        = 4;
    localparam int DIM_W     = 9;
    localparam int CHCFG_W   = 5;
    localparam int POS_W     = $clog2(MAX_COLUMNS);
    localparam int CH_W      = 4;
    localparam int PATCH_W   = 16;
    localparam int ECOL_W    = 6;
    localparam int PHASE_W   = 3;
    localparam int KROW_W    = $clog2(MAX_KERNEL);
    localparam int ADDR_W    = KROW_W + POS_W;
    localparam int STORE_DEPTH = MAX_KERNEL * MAX_COLUMNS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int FIELDS_W = DATA_W + CH_W + PATCH_W + ECOL_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd4;

    typedef struct packed {
        logic [KW-1:0]      kernel;
        logic [SW-1:0]      stride;
        logic [DIM_W-1:0]   rows;
        logic [DIM_W-1:0]   cols;
        logic [CHCFG_W-1:0] chans;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]  pixel;
        logic [ADDR_W-1:0]  wr_addr;
        logic               emit;
        logic [KROW_W-1:0]  base_row;
        logic [POS_W-1:0]   base_col;
        logic [CH_W-1:0]    channel;
        logic [PATCH_W-1:0] patch;
    } job_t;

endpackage

@@ sv/im2col_patch_streamer_unit.sv @@
// Top level of the im2col patch streamer: configuration, front end, job queue and emitter.
//
// Pixels of an already padded tensor arrive one word at a time, channel by channel and
// row-major within a channel; whenever a pixel closes a patch on the stride grid, the
// patch's kernel_width squared elements leave in row-major order. A pixel that closes
// no patch is only written into the line store; one that closes a patch holds the
// emitter until its kernel_width squared elements are read, as the single read port of
// the line store yields one element per cycle while the output is not stalled.
// A four-entry job queue lets the input side run ahead of the emitter while results
// are stalled. The line store needs no clearing after reset and the block is ready at
// once. Configuration must be written only while the block is idle.
module im2col_patch_streamer_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [im2c_pkg::DATA_W-1:0]          s_tdata,   // pixel_word
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // element_word, channel_number, patch_number, element_column, zero padding
    output logic [im2c_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                 m_tlast,   // last_of_patch
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [im2c_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [im2c_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import im2c_pkg::*;

    cfg_t cfg;
    job_t push_job;
    job_t head_job;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    im2c_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    im2c_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_job    (push_job)
    );

    im2c_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    im2c_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (head_valid),
        .q_job    (head_job),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sv/im2c_cfg.sv @@
// Configuration register file with range clamping of each register.
module im2c_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [im2c_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [im2c_pkg::CFG_DATA_W-1:0]  cfg_data,
    output im2c_pkg::cfg_t                   cfg
);
    import im2c_pkg::*;

    logic [KW-1:0]      kernel_reg;
    logic [SW-1:0]      stride_reg;
    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   cols_reg;
    logic [CHCFG_W-1:0] chans_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg <= KW'(3);
            stride_reg <= SW'(1);
            rows_reg   <= DIM_W'(28);
            cols_reg   <= DIM_W'(28);
            chans_reg  <= CHCFG_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_KERNEL:   kernel_reg <= cfg_data[KW-1:0];
                CFG_STRIDE:   stride_reg <= cfg_data[SW-1:0];
                CFG_ROWS:     rows_reg   <= cfg_data[DIM_W-1:0];
                CFG_COLUMNS:  cols_reg   <= cfg_data[DIM_W-1:0];
                CFG_CHANNELS: chans_reg  <= cfg_data[CHCFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.kernel = (kernel_reg == '0) ? KW'(1) :
                     (kernel_reg > KW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : kernel_reg;
        cfg.stride = (stride_reg == '0) ? SW'(1) :
                     (stride_reg > SW'(MAX_STRIDE)) ? SW'(MAX_STRIDE) : stride_reg;
        cfg.rows   = (rows_reg == '0) ? DIM_W'(1) :
                     (rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_reg;
        cfg.cols   = (cols_reg == '0) ? DIM_W'(1) :
                     (cols_reg > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : cols_reg;
        cfg.chans  = (chans_reg == '0) ? CHCFG_W'(1) :
                     (chans_reg > CHCFG_W'(MAX_CHANNELS)) ? CHCFG_W'(MAX_CHANNELS) : chans_reg;
    end

endmodule

@@ sv/im2c_front.sv @@
// Front end: tracks the tensor position and decides which pixels complete a patch.
module im2c_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  im2c_pkg::cfg_t cfg,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [im2c_pkg::DATA_W-1:0] s_tdata,
    input  logic           q_full,
    output logic           q_push,
    output im2c_pkg::job_t q_job
);
    import im2c_pkg::*;

    logic [POS_W-1:0]   row_reg, row_next;
    logic [POS_W-1:0]   col_reg, col_next;
    logic [CH_W-1:0]    chan_reg, chan_next;
    logic [PATCH_W-1:0] patch_reg, patch_next;
    logic [PHASE_W-1:0] vph_reg, vph_next;
    logic [PHASE_W-1:0] hph_reg, hph_next;

    logic [POS_W-1:0]   col_a;
    logic [DIM_W-1:0]   row_a;
    logic [CHCFG_W-1:0] chan_a;
    logic [PATCH_W-1:0] patch_a;
    logic [POS_W-1:0]   r;
    logic [POS_W-1:0]   c;
    logic [KROW_W-1:0]  km1;
    logic [POS_W-1:0]   km1e;
    logic               emit;
    logic [DIM_W-1:0]   col_inc;
    logic [DIM_W-1:0]   row_inc;
    logic [CHCFG_W-1:0] chan_inc;

    function automatic logic [PHASE_W-1:0] advance(input logic [POS_W-1:0] pos,
                                                   input logic [POS_W-1:0] last,
                                                   input logic [PHASE_W-1:0] phase,
                                                   input logic [SW-1:0] step);
        logic [PHASE_W:0] inc;
        inc = {1'b0, phase} + (PHASE_W+1)'(1);
        if (pos == last) begin
            return '0;
        end
        return (inc >= step) ? '0 : inc[PHASE_W-1:0];
    endfunction

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        km1  = KROW_W'(cfg.kernel - KW'(1));
        km1e = POS_W'(km1);

        col_a   = col_reg;
        row_a   = DIM_W'(row_reg);
        chan_a  = CHCFG_W'(chan_reg);
        patch_a = patch_reg;
        if (DIM_W'(col_reg) >= cfg.cols) begin
            col_a = '0;
            row_a = DIM_W'(row_reg) + DIM_W'(1);
        end
        if (row_a >= cfg.rows) begin
            row_a   = '0;
            chan_a  = chan_a + CHCFG_W'(1);
            patch_a = '0;
        end
        if (chan_a >= cfg.chans) begin
            chan_a = '0;
        end
        r = row_a[POS_W-1:0];
        c = col_a;

        vph_next = vph_reg;
        if (c == '0 && r >= km1e) begin
            vph_next = advance(r, km1e, vph_reg, cfg.stride);
        end
        hph_next = hph_reg;
        if (c >= km1e) begin
            hph_next = advance(c, km1e, hph_reg, cfg.stride);
        end
        emit = (r >= km1e) && (c >= km1e) && (vph_next == '0) && (hph_next == '0);

        q_job.pixel    = s_tdata;
        q_job.wr_addr  = {r[KROW_W-1:0], c};
        q_job.emit     = emit;
        q_job.base_row = r[KROW_W-1:0] - km1;
        q_job.base_col = c - km1e;
        q_job.channel  = chan_a[CH_W-1:0];
        q_job.patch    = patch_a;

        patch_next = emit ? patch_a + PATCH_W'(1) : patch_a;
        chan_next  = chan_a[CH_W-1:0];
        row_next   = r;
        col_inc    = DIM_W'(c) + DIM_W'(1);
        row_inc    = DIM_W'(r) + DIM_W'(1);
        chan_inc   = chan_a + CHCFG_W'(1);
        col_next   = col_inc[POS_W-1:0];
        if (col_inc >= cfg.cols) begin
            col_next = '0;
            row_next = row_inc[POS_W-1:0];
            if (row_inc >= cfg.rows) begin
                row_next   = '0;
                patch_next = '0;
                chan_next  = (chan_inc >= cfg.chans) ? '0 : chan_inc[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            chan_reg  <= '0;
            patch_reg <= '0;
            vph_reg   <= '0;
            hph_reg   <= '0;
        end else if (q_push) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            chan_reg  <= chan_next;
            patch_reg <= patch_next;
            vph_reg   <= vph_next;
            hph_reg   <= hph_next;
        end
    end

endmodule

@@ sv/im2c_queue.sv @@
// Short job queue between the front end and the patch emitter.
module im2c_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  im2c_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output im2c_pkg::job_t head_job
);
    import im2c_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

@@ sv/im2c_back.sv @@
// Back end: writes pixels into the line store and reads out each completed patch.
module im2c_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  im2c_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  im2c_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [im2c_pkg::TDATA_W-1:0] m_tdata,
    output logic           m_tlast
);
    import im2c_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic [DATA_W-1:0]  store_mem [STORE_DEPTH];

    logic               state_reg;
    logic [KROW_W-1:0]  i_reg;
    logic [KROW_W-1:0]  j_reg;
    logic [ECOL_W-1:0]  ecol_reg;
    logic [KROW_W-1:0]  base_row_reg;
    logic [POS_W-1:0]   base_col_reg;
    logic [CH_W-1:0]    chan_reg;
    logic [PATCH_W-1:0] patch_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [CH_W-1:0]    out_chan_reg;
    logic [PATCH_W-1:0] out_patch_reg;
    logic [ECOL_W-1:0]  out_ecol_reg;
    logic               out_last_reg;

    logic [KROW_W-1:0]  km1;
    logic               issue;
    logic               last_elem;
    logic [ADDR_W-1:0]  rd_addr;

    always_comb begin
        km1       = KROW_W'(cfg.kernel - KW'(1));
        issue     = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
        last_elem = (i_reg == km1) && (j_reg == km1);
        q_pop     = q_valid && ((state_reg == ST_IDLE) || (issue && last_elem));
        rd_addr   = {base_row_reg + i_reg, base_col_reg + POS_W'(j_reg)};
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            store_mem[q_job.wr_addr] <= q_job.pixel;
        end
        if (issue) begin
            out_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            out_chan_reg  <= chan_reg;
            out_patch_reg <= patch_reg;
            out_ecol_reg  <= ecol_reg;
            out_last_reg  <= last_elem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            ecol_reg      <= '0;
        end else begin
            if (issue) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (issue && !last_elem) begin
                ecol_reg <= ecol_reg + ECOL_W'(1);
                if (j_reg == km1) begin
                    j_reg <= '0;
                    i_reg <= i_reg + KROW_W'(1);
                end else begin
                    j_reg <= j_reg + KROW_W'(1);
                end
            end

            if (q_pop && q_job.emit) begin
                state_reg    <= ST_EMIT;
                i_reg        <= '0;
                j_reg        <= '0;
                ecol_reg     <= '0;
                base_row_reg <= q_job.base_row;
                base_col_reg <= q_job.base_col;
                chan_reg     <= q_job.channel;
                patch_reg    <= q_job.patch;
            end else if (issue && last_elem) begin
                state_reg <= ST_IDLE;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_ecol_reg, out_patch_reg, out_chan_reg, out_data_reg};

endmodule
